@@ rtl/stop_and_wait_arq_sender_assert.svh @@
// assertion macros for the stop-and-wait sender
// used by swarq_engine, which checks its own logic; expects clk and rst_n in scope
`ifndef STOP_AND_WAIT_ARQ_SENDER_ASSERT_SVH
`define STOP_AND_WAIT_ARQ_SENDER_ASSERT_SVH

// same-cycle implication
`define SWARQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWARQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/swarq_pkg.sv @@
// shared types and constants of the stop-and-wait sender
// no dependencies
package swarq_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int PAYLOAD_W   = 16;
  localparam int RETRY_W     = 8;
  localparam int TRY_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam logic [TRY_W-1:0] TRY_MAX = '1;

  localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 16'd1024;
  localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST = 8'd10;

  // item modes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // frame kinds
  localparam logic [1:0] KIND_INITIAL = 2'd0;
  localparam logic [1:0] KIND_MIDDLE  = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] max_payload;
    logic [RETRY_W-1:0]   retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [LENGTH_BITS-1:0] total_bytes;
    logic                   start_seq;
    logic                   ack_bit;
  } item_t;

  typedef struct packed {
    logic                   send_frame;
    logic [1:0]             frame_kind;
    logic                   seq_bit;
    logic [LENGTH_BITS-1:0] payload_offset;
    logic [PAYLOAD_W-1:0]   payload_length;
    logic                   is_resend;
    logic                   done_res;
    logic                   gave_up;
  } res_t;

endpackage

@@ rtl/swarq_cfg.sv @@
// configuration registers: max payload per frame and final-frame tries
// depends on swarq_pkg
module swarq_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swarq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output swarq_pkg::cfg_t                cfg
);
  import swarq_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
      cfg_r.retry_limit <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_wdata[PAYLOAD_W-1:0];
        CFG_RETRY_LIMIT: cfg_r.retry_limit <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/swarq_engine.sv @@
// protocol state and single-pass next-frame logic of the sender
// depends on swarq_pkg and the assertion macro header
`include "stop_and_wait_arq_sender_assert.svh"

module swarq_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  swarq_pkg::item_t item,
  input  swarq_pkg::cfg_t  cfg,
  output swarq_pkg::res_t  res
);
  import swarq_pkg::*;

  logic                   busy_r, busy_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [LENGTH_BITS-1:0] cur_offset_r, cur_offset_nxt;
  logic [PAYLOAD_W-1:0]   cur_length_r, cur_length_nxt;
  logic                   cur_seq_r, cur_seq_nxt;
  logic                   first_frame_r, first_frame_nxt;
  logic                   last_frame_r, last_frame_nxt;
  logic [TRY_W-1:0]       try_count_r, try_count_nxt;

  logic                   do_cut;
  logic                   do_send;
  logic [LENGTH_BITS-1:0] rem;
  logic [PAYLOAD_W-1:0]   mp;
  logic [LENGTH_BITS-1:0] mp_ext;

  assign mp     = (cfg.max_payload == '0) ? PAYLOAD_W'(1) : cfg.max_payload;
  assign mp_ext = LENGTH_BITS'(mp);

  always_comb begin
    busy_nxt        = busy_r;
    bytes_left_nxt  = bytes_left_r;
    cur_offset_nxt  = cur_offset_r;
    cur_length_nxt  = cur_length_r;
    cur_seq_nxt     = cur_seq_r;
    first_frame_nxt = first_frame_r;
    last_frame_nxt  = last_frame_r;
    try_count_nxt   = try_count_r;
    res             = '0;
    do_cut          = 1'b0;
    do_send         = 1'b0;
    rem             = bytes_left_r;

    case (item.mode)
      MODE_START: begin
        busy_nxt        = 1'b1;
        cur_offset_nxt  = '0;
        cur_seq_nxt     = item.start_seq;
        first_frame_nxt = 1'b1;
        rem             = item.total_bytes;
        do_cut          = 1'b1;
        do_send         = 1'b1;
      end
      MODE_ACK: begin
        if (busy_r) begin
          if (item.ack_bit == cur_seq_r) begin
            cur_seq_nxt = ~cur_seq_r;
            if (last_frame_r) begin
              busy_nxt     = 1'b0;
              res.done_res = 1'b1;
            end else begin
              cur_offset_nxt  = cur_offset_r + LENGTH_BITS'(cur_length_r);
              first_frame_nxt = 1'b0;
              do_cut          = 1'b1;
              do_send         = 1'b1;
            end
          end else begin
            do_send = 1'b1;
          end
        end
      end
      MODE_TIMEOUT: begin
        do_send = busy_r;
      end
      default: ;
    endcase

    // cut the next frame
    if (do_cut) begin
      if (rem > mp_ext) begin
        cur_length_nxt = mp;
        last_frame_nxt = 1'b0;
        bytes_left_nxt = rem - mp_ext;
      end else begin
        cur_length_nxt = rem[PAYLOAD_W-1:0];
        last_frame_nxt = 1'b1;
        bytes_left_nxt = '0;
      end
      try_count_nxt = '0;
    end

    // send the current frame and count the try
    if (do_send) begin
      if (try_count_nxt != TRY_MAX) begin
        try_count_nxt = try_count_nxt + TRY_W'(1);
      end
      res.send_frame     = 1'b1;
      res.frame_kind     = last_frame_nxt ? KIND_FINAL :
                           (first_frame_nxt ? KIND_INITIAL : KIND_MIDDLE);
      res.seq_bit        = cur_seq_nxt;
      res.payload_offset = cur_offset_nxt;
      res.payload_length = cur_length_nxt;
      res.is_resend      = (try_count_nxt > TRY_W'(1));
      if (last_frame_nxt && (try_count_nxt > TRY_W'(cfg.retry_limit))) begin
        res.done_res = 1'b1;
        res.gave_up  = 1'b1;
        busy_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      bytes_left_r  <= '0;
      cur_offset_r  <= '0;
      cur_length_r  <= '0;
      cur_seq_r     <= 1'b0;
      first_frame_r <= 1'b1;
      last_frame_r  <= 1'b0;
      try_count_r   <= '0;
    end else if (step_en) begin
      busy_r        <= busy_nxt;
      bytes_left_r  <= bytes_left_nxt;
      cur_offset_r  <= cur_offset_nxt;
      cur_length_r  <= cur_length_nxt;
      cur_seq_r     <= cur_seq_nxt;
      first_frame_r <= first_frame_nxt;
      last_frame_r  <= last_frame_nxt;
      try_count_r   <= try_count_nxt;
    end
  end

  `SWARQ_ASSERT_NEXT(a_done_goes_idle, step_en && res.done_res, !busy_r,
    "transfer finished but sender still busy")
  `SWARQ_ASSERT_NOW(a_last_no_left, last_frame_r, bytes_left_r == '0,
    "final frame with bytes still left")
  `SWARQ_ASSERT_NOW(a_middle_has_left, busy_r && !last_frame_r, bytes_left_r != '0,
    "non-final frame with nothing left")
  `SWARQ_ASSERT_NEXT(a_send_counts_try, step_en && res.send_frame, try_count_r != '0,
    "frame sent without counting a try")

endmodule

@@ rtl/stop_and_wait_arq_sender.sv @@
// stop-and-wait alternating-bit sender: an accepted item sits in the input register until
// the result register can take a new value, which then loads the item's result
// throughput one item per cycle while the output does not stall, both sides may stall independently
// reset (rst_n low, synchronous): idle, both stages empty, max_payload 1024,
// retry limit 10, sequence bit 0; depends on swarq_pkg, swarq_cfg, swarq_engine
module stop_and_wait_arq_sender (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // total_bytes[31:0], start_seq[32], ack_bit[33], zero fill
  input  logic [swarq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // send_frame[0], seq_bit[1], payload_offset[33:2], payload_length[49:34],
  // is_resend[50], done_res[51], gave_up[52], zero fill
  output logic [swarq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // frame_kind[1:0]
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import swarq_pkg::*;

  logic  in_v_r;
  item_t item_r;
  logic  out_v_r;
  res_t  res_r;
  res_t  res;
  cfg_t  cfg;
  logic  adv;
  logic  step_en;

  assign adv       = !out_v_r || out_tready;
  assign step_en   = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode        <= in_tuser;
      item_r.total_bytes <= LENGTH_BITS'(in_tdata[31:0]);
      item_r.start_seq   <= in_tdata[32];
      item_r.ack_bit     <= in_tdata[33];
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  swarq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swarq_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.frame_kind;
  assign out_tdata  = {3'b000, res_r.gave_up, res_r.done_res, res_r.is_resend,
                       res_r.payload_length, res_r.payload_offset[31:0],
                       res_r.seq_bit, res_r.send_frame};

endmodule

@@ bench/testbench.sv @@
// testbench for stop_and_wait_arq_sender: directed frame sequences, then random transfers
// checked against an in-bench mirror of the sender; depends on swarq_pkg and the rtl
module testbench;
  import swarq_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stop_and_wait_arq_sender dut (.*);

  // mirror of the sender state
  cfg_t cfg_shadow;
  logic tx_busy;
  logic [LENGTH_BITS-1:0] tx_left;
  logic [LENGTH_BITS-1:0] tx_offset;
  logic [PAYLOAD_W-1:0] tx_length;
  logic tx_seq;
  logic tx_first;
  logic tx_last;
  logic [TRY_W-1:0] tx_tries;

  res_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 87;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void mirror_reset();
    cfg_shadow.max_payload = MAX_PAYLOAD_RST;
    cfg_shadow.retry_limit = RETRY_LIMIT_RST;
    tx_busy = 1'b0;
    tx_left = '0;
    tx_offset = '0;
    tx_length = '0;
    tx_seq = 1'b0;
    tx_first = 1'b1;
    tx_last = 1'b0;
    tx_tries = '0;
  endfunction

  function automatic void cut_frame(logic [LENGTH_BITS-1:0] rem);
    logic [PAYLOAD_W-1:0] mp;
    mp = (cfg_shadow.max_payload == '0) ? 16'd1 : cfg_shadow.max_payload;
    if (rem > {{(LENGTH_BITS-PAYLOAD_W){1'b0}}, mp}) begin
      tx_length = mp;
      tx_last = 1'b0;
      tx_left = rem - LENGTH_BITS'(mp);
    end else begin
      tx_length = rem[PAYLOAD_W-1:0];
      tx_last = 1'b1;
      tx_left = '0;
    end
    tx_tries = '0;
  endfunction

  function automatic res_t emit_frame();
    res_t r;
    r = '0;
    if (tx_tries != TRY_MAX) tx_tries++;
    r.send_frame = 1'b1;
    r.frame_kind = tx_last ? KIND_FINAL : (tx_first ? KIND_INITIAL : KIND_MIDDLE);
    r.seq_bit = tx_seq;
    r.payload_offset = tx_offset;
    r.payload_length = tx_length;
    r.is_resend = (tx_tries > TRY_W'(1));
    if (tx_last && tx_tries > {1'b0, cfg_shadow.retry_limit}) begin
      r.done_res = 1'b1;
      r.gave_up = 1'b1;
      tx_busy = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t arq_step(item_t it);
    res_t r;
    r = '0;
    if (it.mode == MODE_START) begin
      tx_busy = 1'b1;
      tx_offset = '0;
      tx_seq = it.start_seq;
      tx_first = 1'b1;
      cut_frame(it.total_bytes);
      r = emit_frame();
    end else if (it.mode == MODE_UNUSED || !tx_busy) begin
      r = '0;
    end else if (it.mode == MODE_ACK && it.ack_bit == tx_seq) begin
      tx_seq = ~tx_seq;
      if (tx_last) begin
        tx_busy = 1'b0;
        r.done_res = 1'b1;
      end else begin
        tx_offset = tx_offset + LENGTH_BITS'(tx_length);
        tx_first = 1'b0;
        cut_frame(tx_left);
        r = emit_frame();
      end
    end else begin
      r = emit_frame();
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    res_t got;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.send_frame = out_tdata[0];
      got.seq_bit = out_tdata[1];
      got.payload_offset = out_tdata[33:2];
      got.payload_length = out_tdata[49:34];
      got.is_resend = out_tdata[50];
      got.done_res = out_tdata[51];
      got.gave_up = out_tdata[52];
      got.frame_kind = out_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("send_frame", 32'(want.send_frame), 32'(got.send_frame));
        check_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
        check_field("seq_bit", 32'(want.seq_bit), 32'(got.seq_bit));
        check_field("payload_offset", want.payload_offset, got.payload_offset);
        check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        check_field("is_resend", 32'(want.is_resend), 32'(got.is_resend));
        check_field("done_res", 32'(want.done_res), 32'(got.done_res));
        check_field("gave_up", 32'(want.gave_up), 32'(got.gave_up));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] mode, logic [31:0] total, logic sseq, logic abit);
    item_t it;
    it.mode = mode;
    it.total_bytes = total;
    it.start_seq = sseq;
    it.ack_bit = abit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-34){1'b0}}, abit, sseq, total};
    in_tuser <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), arq_step(it));
    items_sent++;
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(int payload, int retries_word);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_wdata <= payload[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= retries_word[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.max_payload = payload[PAYLOAD_W-1:0];
    cfg_shadow.retry_limit = retries_word[RETRY_W-1:0];
  endtask

  task automatic test_idle_events();
    send_item(MODE_ACK, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(MODE_TIMEOUT, 32'h0, 1'b0, 1'b1);
    send_item(MODE_UNUSED, 32'hA5A5_5A5A, 1'b1, 1'b1);
  endtask

  task automatic test_default_transfer();
    send_item(MODE_START, 32'd2100, 1'b1, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b0);
    send_item(MODE_TIMEOUT, 32'd0, 1'b0, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
  endtask

  task automatic test_empty_and_restart();
    send_item(MODE_START, 32'd0, 1'b0, 1'b0);
    send_item(MODE_UNUSED, 32'd0, 1'b0, 1'b0);
    send_item(MODE_START, 32'd500, 1'b1, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
  endtask

  task automatic test_give_up();
    reconfigure(5, 0);
    send_item(MODE_START, 32'd3, 1'b0, 1'b0);
    reconfigure(0, 'h5A02);
    send_item(MODE_START, 32'd2, 1'b1, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
    send_item(MODE_TIMEOUT, 32'd0, 1'b0, 1'b0);
    send_item(MODE_TIMEOUT, 32'd0, 1'b0, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic test_extremes();
    reconfigure(65535, 'hFFFF);
    send_item(MODE_START, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
    send_item(MODE_START, 32'd65535, 1'b1, 1'b0);
    send_item(MODE_ACK, 32'd0, 1'b0, 1'b1);
  endtask

  task automatic random_transfer();
    int mp;
    int pick;
    mp = (cfg_shadow.max_payload == '0) ? 1 : int'(cfg_shadow.max_payload);
    // sometimes a huge transfer that the next start cuts short
    if ($urandom_range(15) == 0)
      send_item(MODE_START, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_item(MODE_START, 32'($urandom_range(5 * mp)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    while (tx_busy) begin
      pick = int'($urandom_range(99));
      if (pick < 68)
        send_item(MODE_ACK, $urandom, 1'($urandom_range(1)), tx_seq);
      else if (pick < 78)
        send_item(MODE_ACK, $urandom, 1'($urandom_range(1)), ~tx_seq);
      else if (pick < 92)
        send_item(MODE_TIMEOUT, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (pick < 97)
        send_item(MODE_UNUSED, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_item(MODE_START, 32'($urandom_range(3 * mp)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
    if ($urandom_range(7) == 0)
      send_item(2'($urandom_range(1, 3)), $urandom, 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct, int count, int payload_hi,
                                     int retries_hi);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    reconfigure(int'($urandom_range(1, payload_hi)),
                int'(($urandom_range(255) << 8) | $urandom_range(retries_hi)));
    target = items_sent + count;
    while (items_sent < target) random_transfer();
  endtask

  initial begin
    mirror_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_events();
    test_default_transfer();
    test_empty_and_restart();
    test_give_up();
    test_extremes();
    test_random_traffic(24, 87, 120, 8, 3);
    test_random_traffic(24, 87, 120, 200, 255);
    test_random_traffic(87, 24, 120, 1, 1);
    test_random_traffic(87, 24, 120, 64, 0);
    test_random_traffic(0, 0, 120, 32, 5);
    test_random_traffic(0, 0, 120, 65535, 2);
    drain_results();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/swarq_pkg.sv
rtl/swarq_cfg.sv
rtl/swarq_engine.sv
rtl/stop_and_wait_arq_sender.sv
bench/testbench.sv
